/* rtl/core/rrqs_pkg.sv */
// Shared types and constants of the round-robin quantum scheduler.
package rrqs_pkg;

   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_RESTART = 2'd1;
   localparam logic [1:0] CMD_TICK    = 2'd2;

   localparam logic [1:0] CSR_PROCESS_COUNT = 2'd0;
   localparam logic [1:0] CSR_QUANTUM_LIMIT = 2'd1;

   localparam logic [4:0]  PCOUNT_RESET = 5'd1;
   localparam logic [15:0] QLIMIT_RESET = 16'd100;
   localparam logic [7:0]  IDLE_MARK    = 8'h2D;
   localparam logic [15:0] TICK_MAX     = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLR_RD,
      ST_CLR_WR,
      ST_SCAN,
      ST_REQ,
      ST_POP,
      ST_LOOK,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load_wr;
      logic clr_start;
      logic clr_rd;
      logic clr_wr;
      logic tick_start;
      logic scan_step;
      logic requeue;
      logic pop;
      logic look;
      logic run;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic scan_done;
      logic ring_empty;
      logic out_free;
   } status_type;

endpackage

/* rtl/core/round_robin_quantum_scheduler.sv */
// Top level of the round-robin quantum scheduler.
// Load writes one table entry. Restart clears flags, then reads and writes each entry
// in turn to copy its burst. Tick: an arrival scan reads one table entry per cycle over
// the n entries in use, then requeue, dequeue and, if one is queued, look and run steps.
// One item is in work at a time; a result beat waits in an output register.
// Synchronous reset clears flags, ring, tick counter and valid bits; tables hold no reset.
module round_robin_quantum_scheduler #(
   parameter int MAX_PROCS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // slot[3:0], arrival[19:4], burst[27:20], label[35:28]
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // tick[15:0], run_slot[19:16], run_label[27:20],
                                    // first_run[28], completed[29]
   output logic [1:0]  rsp_tuser,   // idle[0], done_res[1]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   rrqs_pkg::cmd_type    cmd;
   rrqs_pkg::status_type status;

   logic [15:0] rsp_tick;
   logic        rsp_idle;
   logic [3:0]  rsp_run_slot;
   logic [7:0]  rsp_run_label;
   logic        rsp_first_run;
   logic        rsp_completed;
   logic        rsp_done;

   assign csr_ready = 1'b1;

   rrqs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .command    (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   rrqs_dpath #(.MAX_PROCS(MAX_PROCS)) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_valid     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_slot      (req_tdata[3:0]),
      .req_arrival   (req_tdata[19:4]),
      .req_burst     (req_tdata[27:20]),
      .req_label     (req_tdata[35:28]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tick      (rsp_tick),
      .rsp_idle      (rsp_idle),
      .rsp_run_slot  (rsp_run_slot),
      .rsp_run_label (rsp_run_label),
      .rsp_first_run (rsp_first_run),
      .rsp_completed (rsp_completed),
      .rsp_done      (rsp_done)
   );

   assign rsp_tdata = {2'b00, rsp_completed, rsp_first_run, rsp_run_label, rsp_run_slot,
                       rsp_tick};
   assign rsp_tuser = {rsp_done, rsp_idle};

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == rrqs_pkg::CMD_TICK)) |=> !req_tready)
      else $error("input taken during tick processing");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser != rrqs_pkg::CMD_TICK) && !rsp_tvalid)
      |=> !rsp_tvalid)
      else $error("result beat without a tick command");

   a_run_result: assert property (@(posedge clock) disable iff (reset)
      cmd.run |=> rsp_tvalid)
      else $error("run step did not load a result beat");

   a_pop_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop || cmd.run) |-> status.out_free)
      else $error("result produced while output register busy");

endmodule

/* rtl/core/rrqs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rrqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/rrqs_ctrl.sv */
// Sequencing state machine of the scheduler: command decode and step control.
module rrqs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [1:0]             command,
   input  rrqs_pkg::status_type   status,
   output rrqs_pkg::cmd_type      cmd
);

   rrqs_pkg::state_type state_ff;
   rrqs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrqs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         rrqs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (command)
                  rrqs_pkg::CMD_LOAD: begin
                     cmd.load_wr = 1'b1;
                  end
                  rrqs_pkg::CMD_RESTART: begin
                     cmd.clr_start = 1'b1;
                     state_in      = rrqs_pkg::ST_CLR_RD;
                  end
                  rrqs_pkg::CMD_TICK: begin
                     cmd.tick_start = 1'b1;
                     state_in       = rrqs_pkg::ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         rrqs_pkg::ST_CLR_RD: begin
            cmd.clr_rd = 1'b1;
            state_in   = rrqs_pkg::ST_CLR_WR;
         end
         rrqs_pkg::ST_CLR_WR: begin
            cmd.clr_wr = 1'b1;
            state_in   = status.clr_last ? rrqs_pkg::ST_IDLE : rrqs_pkg::ST_CLR_RD;
         end
         rrqs_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = rrqs_pkg::ST_REQ;
            end
         end
         rrqs_pkg::ST_REQ: begin
            cmd.requeue = 1'b1;
            state_in    = rrqs_pkg::ST_POP;
         end
         rrqs_pkg::ST_POP: begin
            if (status.out_free) begin
               cmd.pop  = 1'b1;
               state_in = status.ring_empty ? rrqs_pkg::ST_IDLE : rrqs_pkg::ST_LOOK;
            end
         end
         rrqs_pkg::ST_LOOK: begin
            cmd.look = 1'b1;
            state_in = rrqs_pkg::ST_RUN;
         end
         rrqs_pkg::ST_RUN: begin
            if (status.out_free) begin
               cmd.run  = 1'b1;
               state_in = rrqs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rrqs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/rrqs_dpath.sv */
// Scheduler datapath: process tables, progress flags, ready ring and result register.
module rrqs_dpath #(
   parameter int MAX_PROCS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rrqs_pkg::cmd_type      cmd,
   output rrqs_pkg::status_type   status,
   input  logic                   csr_valid,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_data,
   input  logic [3:0]             req_slot,
   input  logic [15:0]            req_arrival,
   input  logic [7:0]             req_burst,
   input  logic [7:0]             req_label,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [15:0]            rsp_tick,
   output logic                   rsp_idle,
   output logic [3:0]             rsp_run_slot,
   output logic [7:0]             rsp_run_label,
   output logic                   rsp_first_run,
   output logic                   rsp_completed,
   output logic                   rsp_done
);

   localparam int IW = $clog2(MAX_PROCS);
   localparam int CW = $clog2(MAX_PROCS + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_PROCS - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(MAX_PROCS);

   logic [4:0]           pcount_ff;
   logic [15:0]          qlimit_ff;
   logic [MAX_PROCS-1:0] started_ff;
   logic [MAX_PROCS-1:0] finished_ff;
   logic [MAX_PROCS-1:0] queued_ff;
   logic [MAX_PROCS-1:0] rem_vld_ff;
   logic [IW-1:0]        head_ff;
   logic [IW-1:0]        tail_ff;
   logic [CW-1:0]        count_ff;
   logic [15:0]          now_ff;
   logic                 last_vld_ff;
   logic [IW-1:0]        last_ff;
   logic [CW-1:0]        n_ff;
   logic                 past_ff;
   logic [CW-1:0]        scan_addr_ff;
   logic                 chk_vld_ff;
   logic [IW-1:0]        chk_idx_ff;
   logic [IW-1:0]        clr_idx_ff;
   logic [IW-1:0]        cur_ff;
   logic                 rsp_valid_ff;
   logic [15:0]          rsp_tick_ff;
   logic                 rsp_idle_ff;
   logic [3:0]           rsp_slot_ff;
   logic [7:0]           rsp_label_ff;
   logic                 rsp_first_ff;
   logic                 rsp_compl_ff;
   logic                 rsp_done_ff;

   logic [CW-1:0]  n_in;
   logic [15:0]    now_inc;
   logic           slot_ok;
   logic           load_we;
   logic           scan_rd;
   logic           scan_ok;
   logic           req_ok;
   logic           push;
   logic [IW-1:0]  push_slot;
   logic           ring_empty;
   logic           out_free;
   logic           rsp_load;
   logic [IW-1:0]  head_nx;
   logic [IW-1:0]  tail_nx;
   logic [15:0]    arr_rdata;
   logic [15:0]    info_rdata;
   logic [IW-1:0]  ring_rdata;
   logic [7:0]     rem_rdata;
   logic [7:0]     rem_eff;
   logic           run_done;
   logic           rem_we;
   logic [IW-1:0]  rem_waddr;
   logic [7:0]     rem_wdata;

   assign slot_ok    = 32'(req_slot) < MAX_PROCS;
   assign load_we    = cmd.load_wr && slot_ok;
   assign n_in       = (32'(pcount_ff) > MAX_PROCS) ? FULL_CNT : CW'(pcount_ff);
   assign now_inc    = (now_ff != rrqs_pkg::TICK_MAX) ? now_ff + 16'd1 : now_ff;
   assign scan_rd    = cmd.scan_step && (scan_addr_ff < n_ff);
   assign ring_empty = (count_ff == '0);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign head_nx    = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign tail_nx    = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;

   assign scan_ok = cmd.scan_step && chk_vld_ff && !queued_ff[chk_idx_ff] &&
                    !finished_ff[chk_idx_ff] && (arr_rdata <= now_ff) &&
                    (started_ff[chk_idx_ff] || !past_ff) &&
                    !(last_vld_ff && (chk_idx_ff == last_ff));
   assign req_ok  = cmd.requeue && last_vld_ff && !finished_ff[last_ff] &&
                    !queued_ff[last_ff];
   assign push      = (scan_ok || req_ok) && (count_ff < FULL_CNT);
   assign push_slot = cmd.requeue ? last_ff : chk_idx_ff;

   assign rem_eff  = rem_vld_ff[cur_ff] ? rem_rdata : 8'd0;
   assign run_done = rem_eff <= 8'd1;
   assign rsp_load = (cmd.pop && ring_empty) || cmd.run;

   assign rem_we    = cmd.clr_wr || cmd.run;
   assign rem_waddr = cmd.run ? cur_ff : clr_idx_ff;
   assign rem_wdata = cmd.run ? (run_done ? 8'd0 : rem_eff - 8'd1) : info_rdata[7:0];

   rrqs_ram #(.WIDTH(16), .DEPTH(MAX_PROCS)) u_arrival_ram (
      .clock (clock),
      .we    (load_we),
      .waddr (IW'(req_slot)),
      .wdata (req_arrival),
      .re    (scan_rd),
      .raddr (scan_addr_ff[IW-1:0]),
      .rdata (arr_rdata)
   );

   rrqs_ram #(.WIDTH(16), .DEPTH(MAX_PROCS)) u_info_ram (
      .clock (clock),
      .we    (load_we),
      .waddr (IW'(req_slot)),
      .wdata ({req_label, req_burst}),
      .re    (cmd.clr_rd || cmd.look),
      .raddr (cmd.look ? ring_rdata : clr_idx_ff),
      .rdata (info_rdata)
   );

   rrqs_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_ring_ram (
      .clock (clock),
      .we    (push),
      .waddr (tail_ff),
      .wdata (push_slot),
      .re    (cmd.pop && !ring_empty),
      .raddr (head_ff),
      .rdata (ring_rdata)
   );

   rrqs_ram #(.WIDTH(8), .DEPTH(MAX_PROCS)) u_rem_ram (
      .clock (clock),
      .we    (rem_we),
      .waddr (rem_waddr),
      .wdata (rem_wdata),
      .re    (cmd.look),
      .raddr (ring_rdata),
      .rdata (rem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff    <= rrqs_pkg::PCOUNT_RESET;
         qlimit_ff    <= rrqs_pkg::QLIMIT_RESET;
         started_ff   <= '0;
         finished_ff  <= '0;
         queued_ff    <= '0;
         rem_vld_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         now_ff       <= '0;
         last_vld_ff  <= 1'b0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               rrqs_pkg::CSR_PROCESS_COUNT: pcount_ff <= csr_data[4:0];
               rrqs_pkg::CSR_QUANTUM_LIMIT: qlimit_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (cmd.clr_start) begin
            started_ff  <= '0;
            finished_ff <= '0;
            queued_ff   <= '0;
            head_ff     <= '0;
            tail_ff     <= '0;
            count_ff    <= '0;
            now_ff      <= '0;
            last_vld_ff <= 1'b0;
         end
         if (cmd.clr_wr) begin
            rem_vld_ff[clr_idx_ff] <= 1'b1;
         end
         if (cmd.tick_start) begin
            chk_vld_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            chk_vld_ff <= scan_rd;
         end
         if (push) begin
            queued_ff[push_slot] <= 1'b1;
            tail_ff              <= tail_nx;
            count_ff             <= count_ff + 1'b1;
         end
         if (cmd.requeue) begin
            last_vld_ff <= 1'b0;
         end
         if (cmd.pop) begin
            if (ring_empty) begin
               if (!past_ff) begin
                  now_ff <= now_inc;
               end
            end else begin
               head_ff  <= head_nx;
               count_ff <= count_ff - 1'b1;
            end
         end
         if (cmd.look) begin
            queued_ff[ring_rdata] <= 1'b0;
         end
         if (cmd.run) begin
            started_ff[cur_ff] <= 1'b1;
            now_ff             <= now_inc;
            if (run_done) begin
               finished_ff[cur_ff] <= 1'b1;
            end else begin
               last_vld_ff <= 1'b1;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_start) begin
         clr_idx_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
      end
      if (cmd.tick_start) begin
         n_ff         <= n_in;
         past_ff      <= now_ff >= qlimit_ff;
         scan_addr_ff <= '0;
      end else if (scan_rd) begin
         scan_addr_ff <= scan_addr_ff + 1'b1;
         chk_idx_ff   <= scan_addr_ff[IW-1:0];
      end
      if (cmd.look) begin
         cur_ff <= ring_rdata;
      end
      if (cmd.run && !run_done) begin
         last_ff <= cur_ff;
      end
      if (rsp_load) begin
         rsp_tick_ff <= now_ff;
         if (cmd.run) begin
            rsp_idle_ff  <= 1'b0;
            rsp_slot_ff  <= 4'(cur_ff);
            rsp_label_ff <= info_rdata[15:8];
            rsp_first_ff <= !started_ff[cur_ff];
            rsp_compl_ff <= run_done;
            rsp_done_ff  <= 1'b0;
         end else begin
            rsp_idle_ff  <= !past_ff;
            rsp_slot_ff  <= '0;
            rsp_label_ff <= past_ff ? 8'd0 : rrqs_pkg::IDLE_MARK;
            rsp_first_ff <= 1'b0;
            rsp_compl_ff <= 1'b0;
            rsp_done_ff  <= past_ff;
         end
      end
   end

   assign status.clr_last   = (clr_idx_ff == LAST_IDX);
   assign status.scan_done  = !(scan_addr_ff < n_ff) && !chk_vld_ff;
   assign status.ring_empty = ring_empty;
   assign status.out_free   = out_free;

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tick      = rsp_tick_ff;
   assign rsp_idle      = rsp_idle_ff;
   assign rsp_run_slot  = rsp_slot_ff;
   assign rsp_run_label = rsp_label_ff;
   assign rsp_first_run = rsp_first_ff;
   assign rsp_completed = rsp_compl_ff;
   assign rsp_done      = rsp_done_ff;

endmodule

/* tb/sv/round_robin_quantum_scheduler_test.sv */
// Self-checking testbench of the round-robin quantum scheduler.
`timescale 1ns / 100ps

module round_robin_quantum_scheduler_test;

   localparam int MAX_PROCS = 16;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 2 * MAX_PROCS + 8;
   localparam int unsigned CYCLE_LIMIT = 4_000_000;
   localparam int unsigned RANDOM_BEATS = 1920;
   localparam int unsigned QUIET_BEATS = 300;

   typedef struct packed {
      logic [15:0] tick;
      logic        idle;
      logic [3:0]  run_slot;
      logic [7:0]  run_label;
      logic        first_run;
      logic        completed;
      logic        done_res;
   } report_type;

   class quantum_timeline;
      bit [15:0] arrival_tab[MAX_PROCS];
      bit [7:0]  burst_tab[MAX_PROCS];
      bit [7:0]  label_tab[MAX_PROCS];
      bit [7:0]  left[MAX_PROCS];
      bit        started[MAX_PROCS];
      bit        finished[MAX_PROCS];
      bit        queued[MAX_PROCS];
      bit [3:0]  ring[MAX_PROCS];
      int        head;
      int        tail;
      int        depth;
      bit [15:0] now_tick;
      bit        last_valid;
      bit [3:0]  last_slot;
      bit [4:0]  proc_count;
      bit [15:0] q_limit;
      report_type pending_reports[$];
      int unsigned mismatches;

      function new();
         proc_count = rrqs_pkg::PCOUNT_RESET;
         q_limit = rrqs_pkg::QLIMIT_RESET;
         restart();
         foreach (left[i]) left[i] = '0;
      endfunction

      function void restart();
         for (int i = 0; i < MAX_PROCS; i++) begin
            left[i] = burst_tab[i];
            started[i] = 1'b0;
            finished[i] = 1'b0;
            queued[i] = 1'b0;
            ring[i] = '0;
         end
         head = 0;
         tail = 0;
         depth = 0;
         now_tick = '0;
         last_valid = 1'b0;
         last_slot = '0;
      endfunction

      function void push_slot(int s);
         if (depth >= MAX_PROCS) return;
         queued[s] = 1'b1;
         ring[tail] = 4'(s);
         tail = (tail + 1) % MAX_PROCS;
         depth++;
      endfunction

      function void note_csr(logic [1:0] index, logic [15:0] value);
         if (index == rrqs_pkg::CSR_PROCESS_COUNT) proc_count = value[4:0];
         else if (index == rrqs_pkg::CSR_QUANTUM_LIMIT) q_limit = value;
      endfunction

      function void note_command(logic [1:0] cmd, logic [3:0] slot, logic [15:0] arrival,
                                 logic [7:0] burst, logic [7:0] label);
         int n;
         bit past;
         int cur;
         report_type rep;
         if (cmd == rrqs_pkg::CMD_LOAD) begin
            arrival_tab[slot] = arrival;
            burst_tab[slot] = burst;
            label_tab[slot] = label;
            return;
         end
         if (cmd == rrqs_pkg::CMD_RESTART) begin
            restart();
            return;
         end
         if (cmd != rrqs_pkg::CMD_TICK) return;

         n = (proc_count > MAX_PROCS) ? MAX_PROCS : int'(proc_count);
         past = now_tick >= q_limit;
         for (int i = 0; i < n; i++) begin
            if (queued[i] || finished[i]) continue;
            if (arrival_tab[i] > now_tick) continue;
            if (!started[i] && past) continue;
            if (last_valid && i == last_slot) continue;
            push_slot(i);
         end
         if (last_valid && !finished[last_slot] && !queued[last_slot]) push_slot(last_slot);
         last_valid = 1'b0;

         rep = '0;
         rep.tick = now_tick;
         if (depth == 0) begin
            if (past) begin
               rep.done_res = 1'b1;
            end else begin
               rep.idle = 1'b1;
               rep.run_label = rrqs_pkg::IDLE_MARK;
               if (now_tick != rrqs_pkg::TICK_MAX) now_tick++;
            end
            pending_reports.push_back(rep);
            return;
         end

         cur = ring[head];
         head = (head + 1) % MAX_PROCS;
         depth--;
         queued[cur] = 1'b0;
         rep.run_slot = 4'(cur);
         rep.run_label = label_tab[cur];
         if (!started[cur]) begin
            started[cur] = 1'b1;
            rep.first_run = 1'b1;
         end
         if (left[cur] <= 8'd1) begin
            left[cur] = '0;
            finished[cur] = 1'b1;
            rep.completed = 1'b1;
         end else begin
            left[cur]--;
            last_valid = 1'b1;
            last_slot = 4'(cur);
         end
         if (now_tick != rrqs_pkg::TICK_MAX) now_tick++;
         pending_reports.push_back(rep);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_report(logic [31:0] data, logic [1:0] user);
         report_type want;
         if (pending_reports.size() == 0) begin
            $error("result beat with nothing pending: tick %0d", data[15:0]);
            mismatches++;
            return;
         end
         want = pending_reports.pop_front();
         compare_field("tick", want.tick, data[15:0]);
         compare_field("idle", want.idle, user[0]);
         compare_field("run_slot", want.run_slot, data[19:16]);
         compare_field("run_label", want.run_label, data[27:20]);
         compare_field("first_run", want.first_run, data[28]);
         compare_field("completed", want.completed, data[29]);
         compare_field("done_res", want.done_res, user[1]);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = rrqs_pkg::CMD_LOAD;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = rrqs_pkg::CSR_PROCESS_COUNT;
   logic [15:0] csr_data = '0;

   quantum_timeline timeline = new();
   bit          gaps_on = 1'b0;
   bit          stalls_on = 1'b0;
   int unsigned beats_sent = 0;
   int unsigned cycle_count = 0;

   round_robin_quantum_scheduler #(
      .MAX_PROCS(MAX_PROCS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always begin
      @(posedge clock);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_tvalid && rsp_tready) timeline.check_report(rsp_tdata, rsp_tuser);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_beat(input logic [1:0] cmd, input logic [3:0] slot,
                            input logic [15:0] arrival, input logic [7:0] burst,
                            input logic [7:0] label);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {4'b0, label, burst, arrival, slot};
      do @(posedge clock); while (!req_tready);
      timeline.note_command(cmd, slot, arrival, burst, label);
      beats_sent++;
   endtask

   task automatic send_random(input logic [1:0] cmd);
      logic [15:0] arrival;
      logic [7:0]  burst;
      int unsigned r;
      r = $urandom_range(0, 9);
      arrival = (r == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
      r = $urandom_range(0, 9);
      burst = (r == 0) ? 8'($urandom) : (r == 1) ? 8'd0 : 8'($urandom_range(1, 6));
      send_beat(cmd, 4'($urandom), arrival, burst, 8'($urandom));
   endtask

   task automatic configure(input logic [4:0] count, input logic [15:0] limit);
      logic [15:0] word;
      word = 16'($urandom);
      word[4:0] = count;
      csr_valid <= 1'b1;
      csr_index <= rrqs_pkg::CSR_PROCESS_COUNT;
      csr_data <= word;
      do @(posedge clock); while (!csr_ready);
      timeline.note_csr(rrqs_pkg::CSR_PROCESS_COUNT, word);
      csr_index <= rrqs_pkg::CSR_QUANTUM_LIMIT;
      csr_data <= limit;
      do @(posedge clock); while (!csr_ready);
      timeline.note_csr(rrqs_pkg::CSR_QUANTUM_LIMIT, limit);
      csr_valid <= 1'b0;
   endtask

   // hold off until every report is in and a restart would have finished
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (timeline.pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned ticks;
      int unsigned r;
      int unsigned phase;
      bit          quiet;
      logic [4:0]  count;
      logic [15:0] limit;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      gaps_on = 1'b1;
      stalls_on = 1'b1;

      // fill every entry before the first restart or tick reads one
      send_beat(rrqs_pkg::CMD_LOAD, 4'd0, 16'd0, 8'd3, 8'hFF);
      send_beat(rrqs_pkg::CMD_LOAD, 4'd15, 16'hFFFF, 8'hFF, 8'h00);
      for (int i = 1; i < MAX_PROCS - 1; i++)
         send_beat(rrqs_pkg::CMD_LOAD, 4'(i), 16'(i), 8'(i % 3), 8'(8'h40 + i));
      send_random(rrqs_pkg::CMD_TICK);
      send_random(rrqs_pkg::CMD_TICK);
      send_random(CMD_UNUSED);
      send_random(rrqs_pkg::CMD_RESTART);
      repeat (4) send_random(rrqs_pkg::CMD_TICK);

      phase = 0;
      while (beats_sent < RANDOM_BEATS) begin
         settle_block();
         case (phase)
            0: begin
               count = 5'd31;
               limit = 16'd0;
            end
            1: begin
               count = 5'd0;
               limit = 16'd1;
            end
            2: begin
               count = 5'(MAX_PROCS);
               limit = 16'hFFFF;
            end
            3: begin
               count = 5'd1;
               limit = 16'd1;
            end
            default: begin
               r = $urandom_range(0, 9);
               count = (r == 0) ? 5'($urandom_range(17, 31)) :
                       (r == 1) ? 5'd0 : 5'($urandom_range(1, MAX_PROCS));
               r = $urandom_range(0, 9);
               limit = (r == 0) ? 16'($urandom) :
                       (r == 1) ? 16'd0 : 16'($urandom_range(1, 40));
            end
         endcase
         configure(count, limit);
         quiet = beats_sent + QUIET_BEATS >= RANDOM_BEATS;
         gaps_on = !quiet && $urandom_range(0, 3) != 0;
         stalls_on = !quiet && $urandom_range(0, 3) != 0;
         repeat ($urandom_range(0, 8)) send_random(rrqs_pkg::CMD_LOAD);
         send_random(rrqs_pkg::CMD_RESTART);
         ticks = $urandom_range(8, 60);
         repeat (ticks) begin
            r = $urandom_range(0, 99);
            if (r < 4) send_random(rrqs_pkg::CMD_LOAD);
            else if (r < 6) send_random(CMD_UNUSED);
            else if (r == 6) send_random(rrqs_pkg::CMD_RESTART);
            else send_random(rrqs_pkg::CMD_TICK);
         end
         phase++;
      end

      settle_block();

      if (timeline.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
